>>> src/handshake_greeting_parser_assert.svh
// assertion macros for the greeting parser
`ifndef HANDSHAKE_GREETING_PARSER_ASSERT_SVH
`define HANDSHAKE_GREETING_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
`define HGP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HGP_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HGP_ASSERT(label, clk, rst_n, prop, msg)
`define HGP_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

>>> src/hgp_pkg.sv
// shared types, constants and the default plugin name table
package hgp_pkg;
    localparam int PLUGIN_MAX_DEF = 32;
    localparam int SCR_MAX = 20;
    localparam int DEFAULT_LEN = 21;
    localparam logic [7:0] PROTO_VERSION = 8'd10;
    localparam logic [7:0] SCR_PART2_DEFAULT = 8'd13;
    localparam int CAP_SECURE_BIT = 15;
    localparam int CAP_PLUGIN_BIT = 19;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_SCRAMBLE = 2'd1;
    localparam logic [1:0] KIND_PLUGIN = 2'd2;

    typedef enum logic [3:0] {
        PH_HDR, PH_PROTO, PH_VERSION, PH_CONNID, PH_SCR1, PH_FILLER, PH_CAPLO,
        PH_CHARSET, PH_STATUS, PH_CAPHI, PH_AUTHLEN, PH_RESERVED, PH_SCR2,
        PH_PLUGIN, PH_DONE
    } t_phase;

    typedef struct packed {
        logic        err;
        logic [7:0]  seq;
        logic [31:0] caps;
        logic [4:0]  scr_len;
        logic [4:0]  plg_len;
        logic        use_default;
    } t_summary;

    function automatic logic [7:0] default_name(input logic [4:0] idx);
        logic [7:0] c;
        unique case (idx)
            5'd0: c = "m"; 5'd1: c = "y"; 5'd2: c = "s"; 5'd3: c = "q";
            5'd4: c = "l"; 5'd5: c = "_"; 5'd6: c = "n"; 5'd7: c = "a";
            5'd8: c = "t"; 5'd9: c = "i"; 5'd10: c = "v"; 5'd11: c = "e";
            5'd12: c = "_"; 5'd13: c = "p"; 5'd14: c = "a"; 5'd15: c = "s";
            5'd16: c = "s"; 5'd17: c = "w"; 5'd18: c = "o"; 5'd19: c = "r";
            5'd20: c = "d";
            default: c = 8'd0;
        endcase
        return c;
    endfunction
endpackage

>>> src/hgp_if.sv
// valid/ready channel interfaces for input and result items
interface hgp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;
    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink (input valid, input in_byte, input last_byte, output ready);
endinterface

interface hgp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  item_kind;
    logic        status;
    logic [7:0]  seq_id;
    logic [31:0] caps_word;
    logic [4:0]  scr_len;
    logic [4:0]  plugin_len;
    logic [7:0]  out_byte;
    logic        last;
    modport source (output valid, output item_kind, output status, output seq_id,
        output caps_word, output scr_len, output plugin_len, output out_byte,
        output last, input ready);
    modport sink (input valid, input item_kind, input status, input seq_id,
        input caps_word, input scr_len, input plugin_len, input out_byte,
        input last, output ready);
endinterface

>>> src/hgp_parse.sv
// byte parser: walks header and payload fields, writes scramble/plugin memory
module hgp_parse #(
    parameter int PLUGIN_MAX = hgp_pkg::PLUGIN_MAX_DEF,
    localparam int PW = $clog2(PLUGIN_MAX)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output logic             o_done,
    output hgp_pkg::t_summary o_sum,
    output logic             o_scr_we,
    output logic [4:0]       o_scr_wa,
    output logic             o_plg_we,
    output logic [PW-1:0]    o_plg_wa,
    output logic [7:0]       o_wd
);
    localparam int NL = (PLUGIN_MAX - 1 < 31) ? PLUGIN_MAX - 1 : 31;
    localparam logic [5:0] NAME_LIMIT = 6'(NL);

    hgp_pkg::t_phase r_phase, n_phase;
    logic [23:0] r_pos, n_pos, r_len, n_len, r_rem, n_rem;
    logic [7:0]  r_seq, n_seq, r_auth, n_auth;
    logic [31:0] r_caps, n_caps;
    logic [4:0]  r_scnt, n_scnt;
    logic [5:0]  r_pcnt, n_pcnt;
    logic        r_err, n_err;
    logic        dec_done;

    always_comb begin
        n_phase = r_phase; n_pos = r_pos; n_len = r_len; n_rem = r_rem;
        n_seq = r_seq; n_auth = r_auth; n_caps = r_caps; n_scnt = r_scnt;
        n_pcnt = r_pcnt; n_err = r_err;
        o_scr_we = 1'b0; o_plg_we = 1'b0;
        o_scr_wa = r_scnt; o_plg_wa = r_pcnt[PW-1:0]; o_wd = i_byte;
        dec_done = (r_rem <= 24'd1);
        if (r_phase == hgp_pkg::PH_HDR) begin
            if (r_pos < 24'd3) begin
                unique case (r_pos[1:0])
                    2'd0: n_len[7:0] = i_byte;
                    2'd1: n_len[15:8] = i_byte;
                    default: n_len[23:16] = i_byte;
                endcase
                n_pos = r_pos + 24'd1;
            end else begin
                n_seq = i_byte; n_pos = '0; n_phase = hgp_pkg::PH_PROTO;
            end
        end else if (r_pos < r_len) begin
            n_pos = r_pos + 24'd1;
            if (!r_err) begin
                if (r_rem != 24'd0) n_rem = r_rem - 24'd1;
                unique case (r_phase)
                    hgp_pkg::PH_PROTO: begin
                        if (i_byte != hgp_pkg::PROTO_VERSION) n_err = 1'b1;
                        else n_phase = hgp_pkg::PH_VERSION;
                    end
                    hgp_pkg::PH_VERSION: begin
                        if (i_byte == 8'd0) begin
                            n_phase = hgp_pkg::PH_CONNID; n_rem = 24'd4;
                        end
                    end
                    hgp_pkg::PH_CONNID: begin
                        if (dec_done) begin
                            n_phase = hgp_pkg::PH_SCR1; n_rem = 24'd8;
                        end
                    end
                    hgp_pkg::PH_SCR1, hgp_pkg::PH_SCR2: begin
                        if (r_scnt < 5'(hgp_pkg::SCR_MAX)) begin
                            o_scr_we = 1'b1; n_scnt = r_scnt + 5'd1;
                        end
                        if (dec_done) begin
                            if (r_phase == hgp_pkg::PH_SCR1) begin
                                n_phase = hgp_pkg::PH_FILLER; n_rem = 24'd1;
                            end else begin
                                n_phase = r_caps[hgp_pkg::CAP_PLUGIN_BIT] ?
                                    hgp_pkg::PH_PLUGIN : hgp_pkg::PH_DONE;
                            end
                        end
                    end
                    hgp_pkg::PH_FILLER: begin
                        n_phase = hgp_pkg::PH_CAPLO; n_rem = 24'd2;
                    end
                    hgp_pkg::PH_CAPLO: begin
                        if (r_rem == 24'd2) n_caps[7:0] = r_caps[7:0] | i_byte;
                        else n_caps[15:8] = r_caps[15:8] | i_byte;
                        if (dec_done) begin
                            n_phase = hgp_pkg::PH_CHARSET; n_rem = 24'd1;
                        end
                    end
                    hgp_pkg::PH_CHARSET: begin
                        n_phase = hgp_pkg::PH_STATUS; n_rem = 24'd2;
                    end
                    hgp_pkg::PH_STATUS: begin
                        if (dec_done) begin
                            n_phase = hgp_pkg::PH_CAPHI; n_rem = 24'd2;
                        end
                    end
                    hgp_pkg::PH_CAPHI: begin
                        if (r_rem == 24'd2) n_caps[23:16] = r_caps[23:16] | i_byte;
                        else n_caps[31:24] = r_caps[31:24] | i_byte;
                        if (dec_done) begin
                            n_phase = hgp_pkg::PH_AUTHLEN; n_rem = 24'd1;
                        end
                    end
                    hgp_pkg::PH_AUTHLEN: begin
                        n_auth = i_byte; n_phase = hgp_pkg::PH_RESERVED;
                        n_rem = 24'd10;
                    end
                    hgp_pkg::PH_RESERVED: begin
                        if (dec_done) begin
                            if (r_caps[hgp_pkg::CAP_SECURE_BIT]) begin
                                n_phase = hgp_pkg::PH_SCR2;
                                n_rem = (r_auth > 8'd8) ? {16'd0, r_auth - 8'd8}
                                                        : {16'd0, hgp_pkg::SCR_PART2_DEFAULT};
                            end else begin
                                n_phase = r_caps[hgp_pkg::CAP_PLUGIN_BIT] ?
                                    hgp_pkg::PH_PLUGIN : hgp_pkg::PH_DONE;
                            end
                        end
                    end
                    hgp_pkg::PH_PLUGIN: begin
                        n_rem = r_rem;
                        if (i_byte == 8'd0) n_phase = hgp_pkg::PH_DONE;
                        else if (r_pcnt < NAME_LIMIT) begin
                            o_plg_we = 1'b1; n_pcnt = r_pcnt + 6'd1;
                        end else begin
                            n_pcnt = NAME_LIMIT + 6'd1; n_phase = hgp_pkg::PH_DONE;
                        end
                    end
                    default: n_rem = r_rem;
                endcase
            end
        end
        if (!i_take) begin
            o_scr_we = 1'b0; o_plg_we = 1'b0;
        end
    end

    logic ok;
    logic dflt;
    always_comb begin
        ok = !r_err && r_phase != hgp_pkg::PH_HDR && r_pos == r_len &&
             (r_phase == hgp_pkg::PH_CHARSET || r_phase >= hgp_pkg::PH_SCR2);
        dflt = (r_pcnt == 6'd0) || (r_pcnt > NAME_LIMIT);
        o_sum.err = !ok;
        o_sum.seq = r_seq;
        o_sum.caps = ok ? r_caps : 32'd0;
        o_sum.scr_len = ok ? r_scnt : 5'd0;
        o_sum.plg_len = !ok ? 5'd0 : (dflt ? 5'(hgp_pkg::DEFAULT_LEN) : r_pcnt[4:0]);
        o_sum.use_default = dflt;
    end

    logic r_done;
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= hgp_pkg::PH_HDR; r_pos <= '0; r_len <= '0; r_rem <= '0;
            r_seq <= '0; r_auth <= '0; r_caps <= '0; r_scnt <= '0; r_pcnt <= '0;
            r_err <= 1'b0; r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_take) begin
                r_phase <= n_phase; r_pos <= n_pos; r_len <= n_len; r_rem <= n_rem;
                r_seq <= n_seq; r_auth <= n_auth; r_caps <= n_caps; r_scnt <= n_scnt;
                r_pcnt <= n_pcnt; r_err <= n_err; r_done <= i_last;
            end else if (r_done) begin
                r_phase <= hgp_pkg::PH_HDR; r_pos <= '0; r_len <= '0; r_rem <= '0;
                r_seq <= '0; r_auth <= '0; r_caps <= '0; r_scnt <= '0; r_pcnt <= '0;
                r_err <= 1'b0;
            end
        end
    end
endmodule

>>> src/hgp_emit.sv
// result sequencer: reads scramble/plugin memories and forms result items
module hgp_emit #(
    parameter int PLUGIN_MAX = hgp_pkg::PLUGIN_MAX_DEF,
    localparam int PW = $clog2(PLUGIN_MAX)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  hgp_pkg::t_summary i_sum,
    input  logic              i_scr_we,
    input  logic [4:0]        i_scr_wa,
    input  logic              i_plg_we,
    input  logic [PW-1:0]     i_plg_wa,
    input  logic [7:0]        i_wd,
    output logic              o_busy,
    hgp_out_if.source         o_res
);
    logic [7:0] scr_mem [hgp_pkg::SCR_MAX];
    logic [7:0] plg_mem [PLUGIN_MAX];
    logic [7:0] r_scr_q, r_plg_q;

    typedef enum logic [1:0] {S_IDLE, S_STATUS, S_SCR, S_PLG} t_state;
    t_state r_state;
    hgp_pkg::t_summary r_sum;
    logic [4:0] r_idx;
    logic [4:0] r_ra;
    logic       fire;

    assign fire = o_res.valid && o_res.ready;

    logic [4:0] ra;
    logic       adv;
    logic       emit_now;
    always_comb begin
        adv = !o_res.valid || o_res.ready;
        ra = r_idx;
        emit_now = adv && ((r_state == S_STATUS) ||
                   ((r_state == S_SCR || r_state == S_PLG) && r_ra == r_idx + 5'd1));
    end

    always_ff @(posedge i_clk) begin
        if (i_scr_we) scr_mem[i_scr_wa] <= i_wd;
        if (i_plg_we) plg_mem[i_plg_wa] <= i_wd;
        r_scr_q <= scr_mem[ra];
        r_plg_q <= plg_mem[PW'(ra)];
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; o_res.valid <= 1'b0; r_idx <= '0; r_ra <= '0;
        end else begin
            if (emit_now) o_res.valid <= 1'b1;
            else if (fire) o_res.valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_sum <= i_sum; r_state <= S_STATUS; r_ra <= '0;
                    end
                end
                S_STATUS: begin
                    if (adv) begin
                        o_res.item_kind <= hgp_pkg::KIND_STATUS;
                        o_res.status <= r_sum.err;
                        o_res.seq_id <= r_sum.seq;
                        o_res.caps_word <= r_sum.caps;
                        o_res.scr_len <= r_sum.scr_len;
                        o_res.plugin_len <= r_sum.plg_len;
                        o_res.out_byte <= 8'd0;
                        o_res.last <= r_sum.err;
                        r_idx <= '0;
                        r_state <= r_sum.err ? S_IDLE :
                                   (r_sum.scr_len != 5'd0 ? S_SCR : S_PLG);
                    end
                end
                S_SCR, S_PLG: begin
                    if (adv && r_ra == r_idx + 5'd1) begin
                        o_res.item_kind <= (r_state == S_SCR) ? hgp_pkg::KIND_SCRAMBLE
                                                              : hgp_pkg::KIND_PLUGIN;
                        o_res.out_byte <= (r_state == S_SCR) ? r_scr_q :
                            (r_sum.use_default ? hgp_pkg::default_name(r_idx) : r_plg_q);
                        if (r_state == S_SCR) begin
                            o_res.last <= 1'b0;
                            if (r_idx + 5'd1 == r_sum.scr_len) begin
                                r_state <= S_PLG; r_idx <= '0; r_ra <= '0;
                            end else begin
                                r_idx <= r_idx + 5'd1;
                            end
                        end else begin
                            o_res.last <= (r_idx + 5'd1 == r_sum.plg_len);
                            if (r_idx + 5'd1 == r_sum.plg_len) r_state <= S_IDLE;
                            else r_idx <= r_idx + 5'd1;
                        end
                    end else if (r_ra == r_idx) begin
                        r_ra <= r_idx + 5'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `include "handshake_greeting_parser_assert.svh"
    `HGP_ASSERT(a_err_single, i_clk, i_rst_n, (fire && o_res.status) |-> o_res.last, "lone status")
    `HGP_ASSERT(a_idle_quiet, i_clk, i_rst_n, (r_state == S_IDLE && !o_res.valid) |=> !fire, "no run")
    `HGP_ASSERT(a_kind_ok, i_clk, i_rst_n, fire |-> (o_res.item_kind != 2'd3), "bad item kind")
endmodule

>>> src/handshake_greeting_parser.sv
// greeting parser: at packet end a run of 1+scramble+plugin items, or a lone error status
// the first result follows the last byte via the done flag and the status state
// throughput: one byte per cycle while no run is pending; input stalls during a run
// the registered memory read paces result items
// reset: synchronous active low, returns parser to header wait and drops any run
module handshake_greeting_parser #(
    parameter int PLUGIN_MAX = hgp_pkg::PLUGIN_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hgp_in_if.sink     i_in,
    hgp_out_if.source  o_res
);
    localparam int PW = $clog2(PLUGIN_MAX);
    logic              take, done, busy, scr_we, plg_we;
    logic [4:0]        scr_wa;
    logic [PW-1:0]     plg_wa;
    logic [7:0]        wd;
    hgp_pkg::t_summary sum;

    assign i_in.ready = !busy && !done;
    assign take = i_in.valid && i_in.ready;

    hgp_parse #(.PLUGIN_MAX(PLUGIN_MAX)) u_parse (
        .i_clk, .i_rst_n, .i_take(take), .i_byte(i_in.in_byte), .i_last(i_in.last_byte),
        .o_done(done), .o_sum(sum), .o_scr_we(scr_we), .o_scr_wa(scr_wa),
        .o_plg_we(plg_we), .o_plg_wa(plg_wa), .o_wd(wd)
    );

    hgp_emit #(.PLUGIN_MAX(PLUGIN_MAX)) u_emit (
        .i_clk, .i_rst_n, .i_start(done), .i_sum(sum), .i_scr_we(scr_we),
        .i_scr_wa(scr_wa), .i_plg_we(plg_we), .i_plg_wa(plg_wa), .i_wd(wd),
        .o_busy(busy), .o_res(o_res)
    );
endmodule

>>> sim/tb_top.sv
// testbench for the greeting parser: packet stimulus, byte-level prediction and result checks
module tb_top;
    localparam int NAME_LIMIT = (hgp_pkg::PLUGIN_MAX_DEF - 1) < 31 ?
                                (hgp_pkg::PLUGIN_MAX_DEF - 1) : 31;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } t_byte;

    typedef struct packed {
        logic [1:0]  kind;
        logic        status;
        logic [7:0]  seq;
        logic [31:0] caps;
        logic [4:0]  scr_len;
        logic [4:0]  plg_len;
        logic [7:0]  data;
        logic        last;
    } t_result;

    logic i_clk;
    logic i_rst_n;
    hgp_in_if  in_ch();
    hgp_out_if res_ch();

    handshake_greeting_parser DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_res   (res_ch.source)
    );

    t_byte   byte_queue[$];
    t_result expected_results[$];
    int      send_idle_pct;
    int      recv_stall_pct;
    int      fail_count;
    int      result_count;
    int      packet_count;
    bit      in_taken;

    // parser state
    hgp_pkg::t_phase ph;
    logic [23:0] pos;
    logic [23:0] dlen;
    logic [7:0]  seq_q;
    logic [31:0] caps_q;
    logic [7:0]  auth_len;
    logic [23:0] remain;
    logic [7:0]  scr_mem[hgp_pkg::SCR_MAX];
    int          scr_cnt;
    logic [7:0]  plg_mem[hgp_pkg::PLUGIN_MAX_DEF];
    int          plg_cnt;
    logic        err;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_parser();
        ph = hgp_pkg::PH_HDR;
        pos = '0;
        dlen = '0;
        seq_q = '0;
        caps_q = '0;
        auth_len = '0;
        remain = '0;
        scr_cnt = 0;
        plg_cnt = 0;
        err = 1'b0;
    endfunction

    function automatic bit count_field();
        if (remain > 0) remain--;
        return remain == 0;
    endfunction

    function automatic void keep_scr(logic [7:0] b);
        if (scr_cnt < hgp_pkg::SCR_MAX) begin
            scr_mem[scr_cnt] = b;
            scr_cnt++;
        end
    endfunction

    function automatic void parse_payload(logic [7:0] b);
        case (ph)
            hgp_pkg::PH_PROTO: begin
                if (b != hgp_pkg::PROTO_VERSION) err = 1'b1;
                else ph = hgp_pkg::PH_VERSION;
            end
            hgp_pkg::PH_VERSION: begin
                if (b == 0) begin ph = hgp_pkg::PH_CONNID; remain = 4; end
            end
            hgp_pkg::PH_CONNID: begin
                if (count_field()) begin ph = hgp_pkg::PH_SCR1; remain = 8; end
            end
            hgp_pkg::PH_SCR1: begin
                keep_scr(b);
                if (count_field()) begin ph = hgp_pkg::PH_FILLER; remain = 1; end
            end
            hgp_pkg::PH_FILLER: begin
                ph = hgp_pkg::PH_CAPLO;
                remain = 2;
            end
            hgp_pkg::PH_CAPLO: begin
                caps_q |= 32'(b) << (remain == 2 ? 0 : 8);
                if (count_field()) begin ph = hgp_pkg::PH_CHARSET; remain = 1; end
            end
            hgp_pkg::PH_CHARSET: begin
                ph = hgp_pkg::PH_STATUS;
                remain = 2;
            end
            hgp_pkg::PH_STATUS: begin
                if (count_field()) begin ph = hgp_pkg::PH_CAPHI; remain = 2; end
            end
            hgp_pkg::PH_CAPHI: begin
                caps_q |= 32'(b) << (remain == 2 ? 16 : 24);
                if (count_field()) begin ph = hgp_pkg::PH_AUTHLEN; remain = 1; end
            end
            hgp_pkg::PH_AUTHLEN: begin
                auth_len = b;
                ph = hgp_pkg::PH_RESERVED;
                remain = 10;
            end
            hgp_pkg::PH_RESERVED: begin
                if (count_field()) begin
                    if (caps_q[hgp_pkg::CAP_SECURE_BIT]) begin
                        ph = hgp_pkg::PH_SCR2;
                        remain = auth_len > 8 ? 24'(auth_len - 8)
                                              : 24'(hgp_pkg::SCR_PART2_DEFAULT);
                    end else begin
                        ph = caps_q[hgp_pkg::CAP_PLUGIN_BIT] ? hgp_pkg::PH_PLUGIN
                                                             : hgp_pkg::PH_DONE;
                    end
                end
            end
            hgp_pkg::PH_SCR2: begin
                keep_scr(b);
                if (count_field())
                    ph = caps_q[hgp_pkg::CAP_PLUGIN_BIT] ? hgp_pkg::PH_PLUGIN
                                                         : hgp_pkg::PH_DONE;
            end
            hgp_pkg::PH_PLUGIN: begin
                if (b == 0) begin
                    ph = hgp_pkg::PH_DONE;
                end else if (plg_cnt < NAME_LIMIT) begin
                    plg_mem[plg_cnt] = b;
                    plg_cnt++;
                end else begin
                    plg_cnt = NAME_LIMIT + 1;
                    ph = hgp_pkg::PH_DONE;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void push_run();
        bit      ok;
        bit      use_def;
        int      pl;
        int      total;
        int      k;
        t_result r;
        ok = !err && ph != hgp_pkg::PH_HDR && pos == dlen &&
             (ph == hgp_pkg::PH_CHARSET || ph >= hgp_pkg::PH_SCR2);
        r = '0;
        r.seq = seq_q;
        if (!ok) begin
            r.kind = hgp_pkg::KIND_STATUS;
            r.status = 1'b1;
            r.last = 1'b1;
            expected_results.push_back(r);
            return;
        end
        use_def = plg_cnt == 0 || plg_cnt > NAME_LIMIT;
        pl = use_def ? hgp_pkg::DEFAULT_LEN : plg_cnt;
        total = 1 + scr_cnt + pl;
        r.caps = caps_q;
        r.scr_len = 5'(scr_cnt);
        r.plg_len = 5'(pl);
        r.kind = hgp_pkg::KIND_STATUS;
        r.last = total == 1;
        expected_results.push_back(r);
        k = 1;
        for (int i = 0; i < scr_cnt; i++) begin
            r.kind = hgp_pkg::KIND_SCRAMBLE;
            r.data = scr_mem[i];
            k++;
            r.last = k == total;
            expected_results.push_back(r);
        end
        for (int i = 0; i < pl; i++) begin
            r.kind = hgp_pkg::KIND_PLUGIN;
            r.data = use_def ? hgp_pkg::default_name(5'(i)) : plg_mem[i];
            k++;
            r.last = k == total;
            expected_results.push_back(r);
        end
    endfunction

    function automatic void predict_byte(t_byte it);
        if (ph == hgp_pkg::PH_HDR) begin
            if (pos < 3) begin
                dlen |= 24'(it.data) << (8 * pos);
                pos++;
            end else begin
                seq_q = it.data;
                pos = '0;
                ph = hgp_pkg::PH_PROTO;
            end
        end else if (pos < dlen) begin
            pos++;
            if (!err) parse_payload(it.data);
        end
        if (it.fin) begin
            push_run();
            clear_parser();
            packet_count++;
        end
    endfunction

    // build a greeting payload; variant picks how far it goes and how it breaks
    task automatic queue_packet(int variant, int cut, bit rand_len, int extra);
        logic [7:0] p[$];
        logic [31:0] caps;
        logic [7:0]  alen;
        int          vlen;
        int          n;
        int          s2;
        int          nlen;
        int          dl;
        caps = $urandom;
        if ($urandom_range(0, 3) != 0) caps[hgp_pkg::CAP_SECURE_BIT] = 1'b1;
        if ($urandom_range(0, 3) != 0) caps[hgp_pkg::CAP_PLUGIN_BIT] = 1'b1;
        p.push_back(variant == 1 ? 8'($urandom_range(0, 255)) : hgp_pkg::PROTO_VERSION);
        vlen = $urandom_range(0, 6);
        for (int i = 0; i < vlen; i++) p.push_back(8'($urandom_range(1, 255)));
        p.push_back(8'd0);
        for (int i = 0; i < 4 + 8 + 1; i++) p.push_back(8'($urandom));
        p.push_back(caps[7:0]);
        p.push_back(caps[15:8]);
        if (variant != 2) begin
            for (int i = 0; i < 3; i++) p.push_back(8'($urandom));
            p.push_back(caps[23:16]);
            p.push_back(caps[31:24]);
            alen = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 21));
            p.push_back(alen);
            for (int i = 0; i < 10; i++) p.push_back(8'($urandom));
            if (caps[hgp_pkg::CAP_SECURE_BIT]) begin
                s2 = alen > 8 ? alen - 8 : 13;
                if (s2 > 40) s2 = $urandom_range(0, 40);
                for (int i = 0; i < s2; i++) p.push_back(8'($urandom));
            end
            if (caps[hgp_pkg::CAP_PLUGIN_BIT]) begin
                case ($urandom_range(0, 4))
                    0: nlen = 0;
                    1: nlen = $urandom_range(31, 36);
                    default: nlen = $urandom_range(1, 30);
                endcase
                for (int i = 0; i < nlen; i++) p.push_back(8'($urandom_range(1, 255)));
                if ($urandom_range(0, 2) != 0) p.push_back(8'd0);
            end
        end
        if (cut > 0 && cut < p.size()) begin
            while (p.size() > cut) void'(p.pop_back());
        end
        dl = p.size();
        if (rand_len) dl = $urandom_range(0, 1) ? 0 : dl + $urandom_range(1, 5);
        for (int i = 0; i < extra; i++) p.push_back(8'($urandom));
        n = p.size();
        byte_queue.push_back('{8'(dl), 1'b0});
        byte_queue.push_back('{8'(dl >> 8), 1'b0});
        byte_queue.push_back('{8'(dl >> 16), 1'b0});
        byte_queue.push_back('{8'($urandom), n == 0});
        for (int i = 0; i < n; i++) byte_queue.push_back('{p[i], i == n - 1});
    endtask

    task automatic queue_partial_header(int nbytes);
        for (int i = 0; i < nbytes; i++)
            byte_queue.push_back('{8'($urandom), i == nbytes - 1});
    endtask

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_taken) begin
            in_taken = 1'b0;
            if (byte_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                in_ch.valid <= 1'b1;
                in_ch.in_byte <= byte_queue[0].data;
                in_ch.last_byte <= byte_queue[0].fin;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
        res_ch.ready <= $urandom_range(0, 99) >= recv_stall_pct;
    end

    // monitor
    always @(posedge i_clk) begin
        t_result got;
        t_result exp_r;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            predict_byte('{in_ch.in_byte, in_ch.last_byte});
            void'(byte_queue.pop_front());
            in_taken = 1'b1;
        end
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = '{res_ch.item_kind, res_ch.status, res_ch.seq_id, res_ch.caps_word,
                    res_ch.scr_len, res_ch.plugin_len, res_ch.out_byte, res_ch.last};
            result_count++;
            if (expected_results.size() == 0) begin
                $error("unexpected result item kind %0d", got.kind);
                fail_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (got.kind !== exp_r.kind) begin
                    $error("item_kind exp %0d got %0d", exp_r.kind, got.kind); fail_count++;
                end
                if (got.status !== exp_r.status) begin
                    $error("status exp %0d got %0d", exp_r.status, got.status); fail_count++;
                end
                if (got.seq !== exp_r.seq) begin
                    $error("seq_id exp %0d got %0d", exp_r.seq, got.seq); fail_count++;
                end
                if (got.caps !== exp_r.caps) begin
                    $error("caps_word exp %h got %h", exp_r.caps, got.caps); fail_count++;
                end
                if (got.scr_len !== exp_r.scr_len) begin
                    $error("scr_len exp %0d got %0d", exp_r.scr_len, got.scr_len);
                    fail_count++;
                end
                if (got.plg_len !== exp_r.plg_len) begin
                    $error("plugin_len exp %0d got %0d", exp_r.plg_len, got.plg_len);
                    fail_count++;
                end
                if (got.data !== exp_r.data) begin
                    $error("out_byte exp %h got %h", exp_r.data, got.data); fail_count++;
                end
                if (got.last !== exp_r.last) begin
                    $error("last exp %0d got %0d", exp_r.last, got.last); fail_count++;
                end
            end
        end
    end

    initial begin
        int v;
        clear_parser();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fail_count = 0;
        result_count = 0;
        packet_count = 0;
        in_taken = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.in_byte = '0;
        in_ch.last_byte = 1'b0;
        res_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: full, short, bad protocol, header cuts, bad lengths, truncations, extras
        queue_packet(0, 0, 0, 0);
        queue_packet(2, 0, 0, 0);
        queue_packet(1, 0, 0, 0);
        queue_partial_header(1);
        queue_partial_header(3);
        queue_partial_header(4);
        queue_packet(0, 0, 1, 0);
        queue_packet(0, 5, 0, 0);
        queue_packet(0, 20, 0, 0);
        queue_packet(0, 0, 0, 3);
        byte_queue.push_back('{8'hff, 1'b0});
        byte_queue.push_back('{8'hff, 1'b0});
        byte_queue.push_back('{8'hff, 1'b0});
        byte_queue.push_back('{8'hff, 1'b1});

        for (int ph_i = 0; ph_i < 4; ph_i++) begin
            send_idle_pct = (ph_i == 1 || ph_i == 3) ? 58 : 0;
            recv_stall_pct = ph_i == 2 ? 58 : (ph_i == 3 ? 19 : 0);
            if (ph_i == 3) send_idle_pct = 19;
            v = $urandom_range(0, 9);
            if (v < 6) queue_packet(0, 0, 0, 0);
            else if (v == 6) queue_packet(2, 0, 0, 0);
            else if (v == 7) queue_packet(0, $urandom_range(1, 40), 0, 0);
            else if (v == 8) queue_packet($urandom_range(0, 1), 0, 1,
                                          $urandom_range(0, 2));
            else queue_partial_header($urandom_range(1, 4));
            while (byte_queue.size() > 0) @(posedge i_clk);
            wait (expected_results.size() == 0);
        end
        repeat (20) @(posedge i_clk);
        $display("covered %0d packets with %0d result items under four idle/stall mixes",
                 packet_count, result_count);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("tb_top failed");
        $finish;
    end
endmodule

>>> handshake_greeting_parser.f
+incdir+src
src/hgp_pkg.sv
src/hgp_if.sv
src/hgp_parse.sv
src/hgp_emit.sv
src/handshake_greeting_parser.sv
sim/tb_top.sv
